FILE: design/spd_pkg.sv
// shared types, codes and field widths for the signal pending dispatch unit
`timescale 1ns / 1ps

package spd_pkg;

    // field widths fixed by the interface
    localparam int SIG_W      = 6;
    localparam int ADDR_W     = 48;
    localparam int PID_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // request codes
    typedef enum logic [1:0] {
        OP_INSTALL = 2'd0,
        OP_RAISE   = 2'd1,
        OP_RETURN  = 2'd2,
        OP_DELIVER = 2'd3
    } opcode_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_INVAL  = 2'd1,
        ST_NOPROC = 2'd2
    } status_code_t;

    // action codes
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ENTER   = 2'd1,
        ACT_TERM    = 2'd2,
        ACT_RESTORE = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USER_THREAD = 1'b0,
        CFG_OWN_PID     = 1'b1
    } cfg_reg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic         install_wr;
        logic         raise_set;
        logic         ret_clear;
        logic         scan_init;
        logic         scan_advance;
        logic         scan_clear;
        logic         mem_rd;
        logic         enter_handler;
        logic         res_load;
        status_code_t res_status;
        action_t      res_action;
        logic         res_sig_sel;
        logic         res_addr_sel;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic sig_bad;
        logic sig_is_kill;
        logic pid_ok;
        logic in_handler;
        logic deliver_blocked;
        logic scan_pending;
        logic scan_is_kill;
        logic scan_is_term;
        logic scan_last;
        logic handler_zero;
    } dp_status_t;

endpackage

FILE: design/signal_pending_dispatch_unit.sv
// top level of the per-thread signal pending and dispatch unit
// install, raise, return and a blocked deliver: result beat in the cycle after accept
// deliver scan: visits signals in order from 1 and reads the handler table for each pending
// signal visited other than the kill signal; busy stays high during the scan
// a new request is taken in the cycle its predecessor's result beat is shown
// reset clears pending bits, handler valid bits and the in-handler flag; no clearing pass
`timescale 1ns / 1ps

module signal_pending_dispatch_unit #(
    parameter int SIGNAL_COUNT = 64,
    parameter int KILL_SIGNAL  = 9,
    parameter int TERM_SIGNAL  = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       opcode,
    input  logic [spd_pkg::SIG_W-1:0]        signal_number,
    input  logic [spd_pkg::ADDR_W-1:0]       handler_entry,
    input  logic [spd_pkg::PID_W-1:0]        target_pid,
    input  logic                             cfg_write,
    input  logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [1:0]                       action,
    output logic [spd_pkg::SIG_W-1:0]        delivered_signal,
    output logic [spd_pkg::ADDR_W-1:0]       handler_address
);

    spd_pkg::dp_cmd_t    cmd;
    spd_pkg::dp_status_t st;

    spd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    spd_datapath #(
        .SIGNAL_COUNT (SIGNAL_COUNT),
        .KILL_SIGNAL  (KILL_SIGNAL),
        .TERM_SIGNAL  (TERM_SIGNAL)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .signal_number    (signal_number),
        .handler_entry    (handler_entry),
        .target_pid       (target_pid),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .st               (st),
        .status           (status),
        .action           (action),
        .delivered_signal (delivered_signal),
        .handler_address  (handler_address)
    );

endmodule

FILE: design/spd_datapath.sv
// datapath: pending bits, handler table, scan counter, config and result registers
`timescale 1ns / 1ps

module spd_datapath #(
    parameter int SIGNAL_COUNT = 64,
    parameter int KILL_SIGNAL  = 9,
    parameter int TERM_SIGNAL  = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [spd_pkg::SIG_W-1:0]        signal_number,
    input  logic [spd_pkg::ADDR_W-1:0]       handler_entry,
    input  logic [spd_pkg::PID_W-1:0]        target_pid,
    input  logic                             cfg_write,
    input  logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  spd_pkg::dp_cmd_t                 cmd,
    output spd_pkg::dp_status_t              st,
    output logic [1:0]                       status,
    output logic [1:0]                       action,
    output logic [spd_pkg::SIG_W-1:0]        delivered_signal,
    output logic [spd_pkg::ADDR_W-1:0]       handler_address
);

    localparam int SW    = spd_pkg::SIG_W;
    localparam int AW    = spd_pkg::ADDR_W;
    localparam int PW    = spd_pkg::PID_W;
    localparam int IDX_W = $clog2(SIGNAL_COUNT);
    localparam logic [SW:0]      SIG_LIMIT = (SW+1)'(SIGNAL_COUNT);
    localparam logic [SW-1:0]    KILL_CODE = SW'(KILL_SIGNAL);
    localparam logic [SW-1:0]    TERM_CODE = SW'(TERM_SIGNAL);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SIGNAL_COUNT - 1);

    // architectural state
    logic [SIGNAL_COUNT-1:0] pending_reg, pending_next;
    logic [SIGNAL_COUNT-1:0] hvalid_reg, hvalid_next;
    logic                    in_handler_reg, in_handler_next;
    logic                    user_reg;
    logic [PW-1:0]           own_pid_reg;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;

    // handler table and its registered read port
    logic [AW-1:0] handler_mem [SIGNAL_COUNT];
    logic [AW-1:0] rd_data_reg;
    logic          rd_valid_reg;

    // result beat registers
    logic [1:0]    status_reg;
    logic [1:0]    action_reg;
    logic [SW-1:0] sig_out_reg;
    logic [AW-1:0] addr_out_reg;

    logic [IDX_W-1:0] req_idx;
    logic [SW-1:0]    scan_sig;

    assign req_idx  = signal_number[IDX_W-1:0];
    assign scan_sig = SW'(scan_idx_reg);

    // status toward the controller
    always_comb
    begin
        st.sig_bad         = (signal_number == '0) || ({1'b0, signal_number} >= SIG_LIMIT);
        st.sig_is_kill     = (signal_number == KILL_CODE);
        st.pid_ok          = user_reg && (target_pid == own_pid_reg);
        st.in_handler      = in_handler_reg;
        st.deliver_blocked = !user_reg || in_handler_reg || (pending_reg == '0);
        st.scan_pending    = pending_reg[scan_idx_reg];
        st.scan_is_kill    = (scan_sig == KILL_CODE);
        st.scan_is_term    = (scan_sig == TERM_CODE);
        st.scan_last       = (scan_idx_reg == LAST_IDX);
        st.handler_zero    = !rd_valid_reg || (rd_data_reg == '0);
    end

    // next state of bitmaps, flag and scan counter
    always_comb
    begin
        pending_next    = pending_reg;
        hvalid_next     = hvalid_reg;
        in_handler_next = in_handler_reg;
        scan_idx_next   = scan_idx_reg;
        if (cmd.raise_set)
        begin
            pending_next[req_idx] = 1'b1;
        end
        if (cmd.scan_clear)
        begin
            pending_next[scan_idx_reg] = 1'b0;
        end
        if (cmd.install_wr)
        begin
            hvalid_next[req_idx] = 1'b1;
        end
        if (cmd.ret_clear)
        begin
            in_handler_next = 1'b0;
        end
        if (cmd.enter_handler)
        begin
            in_handler_next = 1'b1;
        end
        if (cmd.scan_init)
        begin
            scan_idx_next = IDX_W'(1);
        end
        else if (cmd.scan_advance)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            hvalid_reg     <= '0;
            in_handler_reg <= 1'b0;
            scan_idx_reg   <= '0;
            user_reg       <= 1'b1;
            own_pid_reg    <= '0;
        end
        else
        begin
            pending_reg    <= pending_next;
            hvalid_reg     <= hvalid_next;
            in_handler_reg <= in_handler_next;
            scan_idx_reg   <= scan_idx_next;
            if (cfg_write)
            begin
                unique case (spd_pkg::cfg_reg_t'(cfg_index))
                    spd_pkg::CFG_USER_THREAD: user_reg    <= cfg_data[0];
                    spd_pkg::CFG_OWN_PID:     own_pid_reg <= cfg_data[PW-1:0];
                endcase
            end
        end
    end

    // handler table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.install_wr)
        begin
            handler_mem[req_idx] <= handler_entry;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg  <= handler_mem[scan_idx_reg];
            rd_valid_reg <= hvalid_reg[scan_idx_reg];
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg   <= cmd.res_status;
            action_reg   <= cmd.res_action;
            sig_out_reg  <= cmd.res_sig_sel ? scan_sig : '0;
            addr_out_reg <= cmd.res_addr_sel ? rd_data_reg : '0;
        end
    end

    assign status           = status_reg;
    assign action           = action_reg;
    assign delivered_signal = sig_out_reg;
    assign handler_address  = addr_out_reg;

endmodule

FILE: design/spd_ctrl.sv
// controller state machine: request decode and delivery scan sequencing
`timescale 1ns / 1ps

module spd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          opcode,
    input  spd_pkg::dp_status_t st,
    output spd_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOOKUP
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        cmd            = '0;
        cmd.res_status = spd_pkg::ST_OK;
        cmd.res_action = spd_pkg::ACT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (spd_pkg::opcode_t'(opcode))
                        spd_pkg::OP_INSTALL:
                        begin
                            cmd.res_load = 1'b1;
                            done_next    = 1'b1;
                            if (st.sig_bad || st.sig_is_kill)
                            begin
                                cmd.res_status = spd_pkg::ST_INVAL;
                            end
                            else
                            begin
                                cmd.install_wr = 1'b1;
                            end
                        end
                        spd_pkg::OP_RAISE:
                        begin
                            cmd.res_load = 1'b1;
                            done_next    = 1'b1;
                            priority if (st.sig_bad)
                            begin
                                cmd.res_status = spd_pkg::ST_INVAL;
                            end
                            else if (!st.pid_ok)
                            begin
                                cmd.res_status = spd_pkg::ST_NOPROC;
                            end
                            else
                            begin
                                cmd.raise_set = 1'b1;
                            end
                        end
                        spd_pkg::OP_RETURN:
                        begin
                            cmd.res_load = 1'b1;
                            done_next    = 1'b1;
                            if (!st.in_handler)
                            begin
                                cmd.res_status = spd_pkg::ST_INVAL;
                            end
                            else
                            begin
                                cmd.ret_clear  = 1'b1;
                                cmd.res_action = spd_pkg::ACT_RESTORE;
                            end
                        end
                        spd_pkg::OP_DELIVER:
                        begin
                            if (st.deliver_blocked)
                            begin
                                cmd.res_load = 1'b1;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            // visit one signal per cycle until one is pending; fetch its handler unless it is kill
            S_SCAN:
            begin
                if (st.scan_pending)
                begin
                    cmd.scan_clear = 1'b1;
                    if (st.scan_is_kill)
                    begin
                        cmd.res_load    = 1'b1;
                        cmd.res_action  = spd_pkg::ACT_TERM;
                        cmd.res_sig_sel = 1'b1;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = S_LOOKUP;
                    end
                end
                else if (st.scan_last)
                begin
                    cmd.res_load = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.scan_advance = 1'b1;
                end
            end
            // handler word is back: enter, terminate, or drop and go on, finishing after the last signal
            S_LOOKUP:
            begin
                priority if (!st.handler_zero)
                begin
                    cmd.enter_handler = 1'b1;
                    cmd.res_load      = 1'b1;
                    cmd.res_action    = spd_pkg::ACT_ENTER;
                    cmd.res_sig_sel   = 1'b1;
                    cmd.res_addr_sel  = 1'b1;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (st.scan_is_term)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_action  = spd_pkg::ACT_TERM;
                    cmd.res_sig_sel = 1'b1;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (st.scan_last)
                begin
                    cmd.res_load = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.scan_advance = 1'b1;
                    state_next       = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

FILE: design/spd_checker.sv
// port-level checker for the signal dispatch unit, bound to the top level
`timescale 1ns / 1ps

module spd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 opcode,
    input logic                       done,
    input logic [1:0]                 status,
    input logic [1:0]                 action,
    input logic [spd_pkg::SIG_W-1:0]  delivered_signal,
    input logic [spd_pkg::ADDR_W-1:0] handler_address
);

    // a result beat only shows while the unit is free
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // non-deliver requests answer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode != spd_pkg::OP_DELIVER)) |=> done)
        else $error("missing single-cycle answer");

    // entering a handler names a real signal and a nonzero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action == spd_pkg::ACT_ENTER)) |->
        ((handler_address != '0) && (delivered_signal != '0)))
        else $error("handler entry without address or signal");

    // the address is zero unless a handler is entered
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action != spd_pkg::ACT_ENTER)) |-> (handler_address == '0))
        else $error("stray handler address");

    // any action other than none carries status ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action != spd_pkg::ACT_NONE)) |-> (status == spd_pkg::ST_OK))
        else $error("action with error status");

endmodule

bind signal_pending_dispatch_unit spd_checker u_spd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .done             (done),
    .status           (status),
    .action           (action),
    .delivered_signal (delivered_signal),
    .handler_address  (handler_address)
);

FILE: dv/tb.sv
// self-checking testbench for the signal pending and dispatch unit
`timescale 1ns / 1ps

module tb;

    localparam int NSIG        = 64;
    localparam int KILL_SIG    = 9;
    localparam int TERM_SIG    = 15;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 2 * NSIG + 8;

    // field widths of the unit
    localparam int SIG_W      = spd_pkg::SIG_W;
    localparam int ADDR_W     = spd_pkg::ADDR_W;
    localparam int PID_W      = spd_pkg::PID_W;
    localparam int CFG_IDX_W  = spd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = spd_pkg::CFG_DATA_W;

    // one reply beat as the unit presents it
    typedef struct {
        spd_pkg::status_code_t status;
        spd_pkg::action_t      act;
        logic [SIG_W-1:0]      sig;
        logic [ADDR_W-1:0]     addr;
    } reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             opcode;
    logic [SIG_W-1:0]       signal_number;
    logic [ADDR_W-1:0]      handler_entry;
    logic [PID_W-1:0]       target_pid;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    logic [1:0]             status;
    logic [1:0]             action;
    logic [SIG_W-1:0]       delivered_signal;
    logic [ADDR_W-1:0]      handler_address;

    // predicted unit state and register copies
    logic [NSIG-1:0]        pending_mask;
    logic [ADDR_W-1:0]      handler_vec [NSIG];
    logic                   handler_active;
    logic                   user_mode;
    logic [PID_W-1:0]       owner_pid;

    reply_t                 expected_replies [$];
    int                     error_count;
    int                     cycle_count;
    int                     gap_pct;

    signal_pending_dispatch_unit #(
        .SIGNAL_COUNT (NSIG),
        .KILL_SIGNAL  (KILL_SIG),
        .TERM_SIGNAL  (TERM_SIG)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .signal_number    (signal_number),
        .handler_entry    (handler_entry),
        .target_pid       (target_pid),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .status           (status),
        .action           (action),
        .delivered_signal (delivered_signal),
        .handler_address  (handler_address)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic reply_t make_reply(spd_pkg::status_code_t st, spd_pkg::action_t act,
                                          logic [SIG_W-1:0] sig, logic [ADDR_W-1:0] addr);
        reply_t r;
        r.status = st;
        r.act    = act;
        r.sig    = sig;
        r.addr   = addr;
        return r;
    endfunction

    // predicted reply for one request, updates the predicted state
    function automatic reply_t predict_reply(spd_pkg::opcode_t op, logic [SIG_W-1:0] sig,
                                             logic [ADDR_W-1:0] entry,
                                             logic [PID_W-1:0] pid);
        logic sig_invalid;
        sig_invalid = (sig == 0) || (int'(sig) >= NSIG);
        case (op)
            spd_pkg::OP_INSTALL:
            begin
                if (sig_invalid || sig == KILL_SIG)
                    return make_reply(spd_pkg::ST_INVAL, spd_pkg::ACT_NONE, '0, '0);
                handler_vec[sig] = entry;
                return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_NONE, '0, '0);
            end
            spd_pkg::OP_RAISE:
            begin
                if (sig_invalid)
                    return make_reply(spd_pkg::ST_INVAL, spd_pkg::ACT_NONE, '0, '0);
                if (!user_mode || pid != owner_pid)
                    return make_reply(spd_pkg::ST_NOPROC, spd_pkg::ACT_NONE, '0, '0);
                pending_mask[sig] = 1'b1;
                return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_NONE, '0, '0);
            end
            spd_pkg::OP_RETURN:
            begin
                if (!handler_active)
                    return make_reply(spd_pkg::ST_INVAL, spd_pkg::ACT_NONE, '0, '0);
                handler_active = 1'b0;
                return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_RESTORE, '0, '0);
            end
            default:
            begin
                if (!user_mode || handler_active || pending_mask == '0)
                    return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_NONE, '0, '0);
                // lowest pending signal with an effect wins; visited bits are cleared
                for (int s = 1; s < NSIG; s++)
                begin
                    if (pending_mask[s])
                    begin
                        pending_mask[s] = 1'b0;
                        if (s == KILL_SIG)
                            return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_TERM,
                                              SIG_W'(s), '0);
                        if (handler_vec[s] == '0)
                        begin
                            if (s == TERM_SIG)
                                return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_TERM,
                                                  SIG_W'(s), '0);
                        end
                        else
                        begin
                            handler_active = 1'b1;
                            return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_ENTER,
                                              SIG_W'(s), handler_vec[s]);
                        end
                    end
                end
                return make_reply(spd_pkg::ST_OK, spd_pkg::ACT_NONE, '0, '0);
            end
        endcase
    endfunction

    // reply checker, sampled mid-cycle so it is clear of the driving edge
    always @(negedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("reply beat with no request outstanding");
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (action !== want.act)
                    report_mismatch($sformatf("action %0d, want %0d", action, want.act));
                if (delivered_signal !== want.sig)
                    report_mismatch($sformatf("delivered_signal %0d, want %0d",
                                              delivered_signal, want.sig));
                if (handler_address !== want.addr)
                    report_mismatch($sformatf("handler_address %h, want %h",
                                              handler_address, want.addr));
            end
        end
    end

    // send one request beat; entered and left at a rising edge
    task automatic send_request(input spd_pkg::opcode_t op, input logic [SIG_W-1:0] sig,
                                input logic [ADDR_W-1:0] entry,
                                input logic [PID_W-1:0] pid);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        opcode        <= op;
        signal_number <= sig;
        handler_entry <= entry;
        target_pid    <= pid;
        do
            @(negedge clk);
        while (busy);
        expected_replies.push_back(predict_reply(op, sig, entry, pid));
        @(posedge clk);
    endtask

    // random request, mostly well formed so the scan sees real work
    task automatic send_random_request();
        spd_pkg::opcode_t  op;
        logic [SIG_W-1:0]  sig;
        logic [ADDR_W-1:0] entry;
        logic [PID_W-1:0]  pid;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 20)
            op = spd_pkg::OP_INSTALL;
        else if (pick < 55)
            op = spd_pkg::OP_RAISE;
        else if (pick < 70)
            op = spd_pkg::OP_RETURN;
        else
            op = spd_pkg::OP_DELIVER;
        pick = $urandom_range(99);
        if (pick < 5)
            sig = '0;
        else if (pick < 12)
            sig = SIG_W'(KILL_SIG);
        else if (pick < 20)
            sig = SIG_W'(TERM_SIG);
        else
            sig = SIG_W'($urandom_range(NSIG - 1, 1));
        pick = $urandom_range(99);
        if (pick < 30)
            entry = '0;
        else if (pick < 35)
            entry = '1;
        else
            entry = ADDR_W'({$urandom, $urandom});
        if ($urandom_range(99) < 85)
            pid = owner_pid;
        else
            pid = PID_W'($urandom);
        send_request(op, sig, entry, pid);
    endtask

    // drop start and let every outstanding reply come back
    task automatic quiesce();
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write both registers while the unit is idle
    task automatic set_config(input logic user, input logic [PID_W-1:0] pid);
        cfg_write <= 1'b1;
        cfg_index <= spd_pkg::CFG_USER_THREAD;
        cfg_data  <= CFG_DATA_W'(user);
        @(posedge clk);
        cfg_index <= spd_pkg::CFG_OWN_PID;
        cfg_data  <= pid;
        @(posedge clk);
        cfg_write <= 1'b0;
        user_mode = user;
        owner_pid = pid;
    endtask

    // corner requests from the reset configuration (user thread, pid 0)
    task automatic test_directed();
        gap_pct = 0;
        send_request(spd_pkg::OP_INSTALL, 6'd0, '1, 16'h0000);
        send_request(spd_pkg::OP_INSTALL, SIG_W'(KILL_SIG), 48'h1234, 16'h0000);
        send_request(spd_pkg::OP_INSTALL, 6'd63, '1, 16'hFFFF);
        send_request(spd_pkg::OP_INSTALL, 6'd1, 48'h0000_0000_1000, 16'h0000);
        send_request(spd_pkg::OP_RAISE, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_RAISE, 6'd5, '0, 16'hFFFF);
        send_request(spd_pkg::OP_RETURN, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_RAISE, 6'd1, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        // deliver while a handler runs is held off
        send_request(spd_pkg::OP_RAISE, 6'd63, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_RETURN, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd63, '1, 16'hFFFF);
        send_request(spd_pkg::OP_RETURN, 6'd63, '1, 16'hFFFF);
        // dropped signal below a kill, then terminate without handler
        send_request(spd_pkg::OP_RAISE, 6'd3, '0, 16'h0000);
        send_request(spd_pkg::OP_RAISE, SIG_W'(TERM_SIG), '0, 16'h0000);
        send_request(spd_pkg::OP_RAISE, SIG_W'(KILL_SIG), '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        // scan runs off the end after dropping everything
        send_request(spd_pkg::OP_RAISE, 6'd7, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        send_request(spd_pkg::OP_INSTALL, 6'd1, '0, 16'h0000);
        send_request(spd_pkg::OP_RAISE, 6'd1, '0, 16'h0000);
        send_request(spd_pkg::OP_DELIVER, 6'd0, '0, 16'h0000);
        quiesce();
    endtask

    // random traffic with a light sender gap
    task automatic test_random_light_gaps();
        set_config(1'b1, PID_W'($urandom));
        gap_pct = 34;
        repeat (400) send_random_request();
        quiesce();
    endtask

    // random traffic with a heavy sender gap at the top pid
    task automatic test_random_heavy_gaps();
        set_config(1'b1, 16'hFFFF);
        gap_pct = 72;
        repeat (350) send_random_request();
        quiesce();
    endtask

    // kernel thread: raises refused and deliveries held off
    task automatic test_kernel_thread();
        set_config(1'b0, 16'hFFFF);
        gap_pct = 72;
        repeat (100) send_random_request();
        quiesce();
    endtask

    // back-to-back random traffic at pid 0
    task automatic test_random_back_to_back();
        set_config(1'b1, 16'h0000);
        gap_pct = 0;
        repeat (300) send_random_request();
        quiesce();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = '0;
        signal_number  = '0;
        handler_entry  = '0;
        target_pid     = '0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        error_count    = 0;
        cycle_count    = 0;
        gap_pct        = 0;
        pending_mask   = '0;
        handler_active = 1'b0;
        user_mode      = 1'b1;
        owner_pid      = '0;
        foreach (handler_vec[i])
            handler_vec[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_light_gaps();
        test_random_heavy_gaps();
        test_kernel_thread();
        test_random_back_to_back();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
design/spd_pkg.sv
design/spd_datapath.sv
design/spd_ctrl.sv
design/signal_pending_dispatch_unit.sv
design/spd_checker.sv
dv/tb.sv
